@@ src/sdcs_pkg.sv @@
// Package for the SD card command sequencer: phase, status and code types.
// No dependencies.
package sdcs_pkg;

    typedef enum logic [20:0] {
        PH_IDLE     = 21'd1 << 0,
        PH_SLOW     = 21'd1 << 1,
        PH_CMD0     = 21'd1 << 2,
        PH_CMD8     = 21'd1 << 3,
        PH_CMD55    = 21'd1 << 4,
        PH_ACMD41   = 21'd1 << 5,
        PH_CMD2     = 21'd1 << 6,
        PH_CMD3     = 21'd1 << 7,
        PH_FAST     = 21'd1 << 8,
        PH_CMD9     = 21'd1 << 9,
        PH_CMD7     = 21'd1 << 10,
        PH_CMD16    = 21'd1 << 11,
        PH_DEINIT   = 21'd1 << 12,
        PH_RD_DATA  = 21'd1 << 13,
        PH_RD_STOP  = 21'd1 << 14,
        PH_WR_DATA  = 21'd1 << 15,
        PH_WR_STOP  = 21'd1 << 16,
        PH_ER_START = 21'd1 << 17,
        PH_ER_END   = 21'd1 << 18,
        PH_ER_ERASE = 21'd1 << 19,
        PH_POLL     = 21'd1 << 20
    } phase_t;

    localparam logic [2:0] CMD_INIT = 3'd0, CMD_DEINIT = 3'd1, CMD_READ = 3'd2,
        CMD_WRITE = 3'd3, CMD_ERASE = 3'd4, CMD_REPLY = 3'd5, CMD_TICK = 3'd6;

    localparam logic [2:0] ACT_NONE = 3'd0, ACT_CMD = 3'd1, ACT_SLOW = 3'd2,
        ACT_FAST = 3'd3, ACT_OFF = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0, ST_INVAL = 3'd1, ST_HW = 3'd2,
        ST_TIMEOUT = 3'd3, ST_XPORT = 3'd4;

    localparam logic [2:0] RK_NONE = 3'd0, RK_R1 = 3'd1, RK_R1B = 3'd2,
        RK_R2 = 3'd3, RK_R3 = 3'd4, RK_R6 = 3'd5, RK_R7 = 3'd6;

    localparam logic [1:0] DIR_NONE = 2'd0, DIR_READ = 2'd1, DIR_WRITE = 2'd2;
    localparam logic [1:0] RS_OK = 2'd0, RS_NORESP = 2'd1;

    localparam logic [31:0] HZ_SLOW = 32'd400000;
    localparam logic [31:0] HZ_FAST = 32'd25000000;
    localparam logic [3:0] CARD_TRAN = 4'd4;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [2:0]  resp_kind;
        logic [1:0]  data_dir;
        logic [31:0] xfer_blocks;
        logic        done_res;
        logic [2:0]  status;
    } result_t;

endpackage

@@ src/sd_card_command_sequencer_unit.sv @@
// SD card native-mode command sequencer, top level.
// Results are registered in the output register, or in its skid stage when stalled.
// Throughput: one transaction per cycle while the skid stage is empty; the result
// register and its skid stage let input be accepted while a result waits for m_ready.
// Reset (synchronous, aresetn low) returns to idle and clears all card state;
// timeout_reg returns to 1000.
module sd_card_command_sequencer_unit #(
    parameter int BLOCK_SHIFT = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [31:0] s_block_index,
    input  logic [31:0] s_block_total,
    input  logic [1:0]  s_reply_status,
    input  logic [31:0] s_reply_word0,
    input  logic [31:0] s_reply_word1,
    input  logic [31:0] s_reply_word2,
    input  logic [31:0] s_reply_word3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [5:0]  m_cmd_index,
    output logic [31:0] m_cmd_arg,
    output logic [2:0]  m_resp_kind,
    output logic [1:0]  m_data_dir,
    output logic [31:0] m_xfer_blocks,
    output logic        m_done_res,
    output logic [2:0]  m_status
);
    import sdcs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        hc_reg, hc_next, v2_reg, v2_next, multi_reg, multi_next;
    logic [15:0] rca_reg, rca_next;
    logic [31:0] cap_reg, cap_next, elapsed_reg, elapsed_next;
    logic [31:0] end_reg, end_next, timeout_reg;
    logic [2:0]  ferr_reg, ferr_next;
    logic [31:0] csd_cap;
    result_t     res;
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        accept;

    logic [2:0]  rerr, stop_err;
    logic        range_bad, timed_out;
    logic [31:0] rca_arg, addr_first, addr_last, last_blk;

    sdcs_csd_decode u_csd (
        .word1   (s_reply_word1),
        .word2   (s_reply_word2),
        .word3   (s_reply_word3),
        .capacity(csd_cap)
    );

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // Helpers shared by several phases.
    always_comb begin
        rerr = (s_reply_status == RS_OK) ? ST_OK :
               (s_reply_status == RS_NORESP) ? ST_TIMEOUT : ST_XPORT;
        stop_err   = (ferr_reg != ST_OK) ? ferr_reg : rerr;
        range_bad  = (s_block_total == 32'd0) || (s_block_index > cap_reg) ||
                     (s_block_total > cap_reg - s_block_index);
        timed_out  = elapsed_reg >= timeout_reg;
        rca_arg    = {rca_reg, 16'd0};
        last_blk   = s_block_index + s_block_total - 32'd1;
        addr_first = hc_reg ? s_block_index : (s_block_index << BLOCK_SHIFT);
        addr_last  = hc_reg ? last_blk : (last_blk << BLOCK_SHIFT);
    end

    // Next-state and result logic for one transaction.
    always_comb begin
        phase_next = phase_reg; hc_next = hc_reg; v2_next = v2_reg;
        multi_next = multi_reg; rca_next = rca_reg; cap_next = cap_reg;
        elapsed_next = elapsed_reg; end_next = end_reg; ferr_next = ferr_reg;
        res = '0;
        if (s_cmd == CMD_TICK) begin
            if ((phase_reg == PH_CMD55 || phase_reg == PH_ACMD41 ||
                 phase_reg == PH_POLL) && elapsed_reg != 32'hFFFF_FFFF) begin
                elapsed_next = elapsed_reg + 32'd1;
            end
        end else if (s_cmd == CMD_REPLY) begin
            if (phase_reg != PH_IDLE) begin
                res.done_res = 1'b1; res.status = rerr; phase_next = PH_IDLE;
                unique case (phase_reg)
                    PH_CMD8: begin
                        if (s_reply_status == RS_OK && s_reply_word0[7:0] != 8'hAA) begin
                            res.status = ST_HW;
                        end else if (s_reply_status == RS_OK ||
                                     s_reply_status == RS_NORESP) begin
                            v2_next = (s_reply_status == RS_OK);
                            elapsed_next = '0;
                            res = '0; res.action = ACT_CMD; res.cmd_index = 6'd55;
                            res.resp_kind = RK_R1; phase_next = PH_CMD55;
                        end else begin
                            res.status = ST_XPORT;
                        end
                    end
                    PH_RD_DATA, PH_WR_DATA: begin
                        if (multi_reg) begin
                            ferr_next = rerr;
                            res = '0; res.action = ACT_CMD; res.cmd_index = 6'd12;
                            res.resp_kind = RK_R1B;
                            phase_next = (phase_reg == PH_RD_DATA) ? PH_RD_STOP : PH_WR_STOP;
                        end else if (rerr == ST_OK && phase_reg == PH_WR_DATA) begin
                            elapsed_next = '0;
                            res = '0; res.action = ACT_CMD; res.cmd_index = 6'd13;
                            res.cmd_arg = rca_arg; res.resp_kind = RK_R1;
                            phase_next = PH_POLL;
                        end
                    end
                    PH_RD_STOP, PH_WR_STOP: begin
                        res.status = stop_err;
                        if (stop_err == ST_OK && phase_reg == PH_WR_STOP) begin
                            elapsed_next = '0;
                            res = '0; res.action = ACT_CMD; res.cmd_index = 6'd13;
                            res.cmd_arg = rca_arg; res.resp_kind = RK_R1;
                            phase_next = PH_POLL;
                        end
                    end
                    default: begin
                        if (rerr == ST_OK) begin
                            res = '0; res.action = ACT_CMD;
                            unique case (phase_reg)
                                PH_SLOW: begin
                                    res.cmd_index = 6'd0; phase_next = PH_CMD0;
                                end
                                PH_CMD0: begin
                                    res.cmd_index = 6'd8; res.cmd_arg = 32'h1AA;
                                    res.resp_kind = RK_R7; phase_next = PH_CMD8;
                                end
                                PH_CMD55: begin
                                    res.cmd_index = 6'd41;
                                    res.cmd_arg = 32'h00FF_8000 | (v2_reg ? 32'h4000_0000 : '0);
                                    res.resp_kind = RK_R3; phase_next = PH_ACMD41;
                                end
                                PH_ACMD41: begin
                                    if (s_reply_word0[31]) begin
                                        hc_next = s_reply_word0[30];
                                        res.cmd_index = 6'd2; res.resp_kind = RK_R2;
                                        phase_next = PH_CMD2;
                                    end else if (timed_out) begin
                                        res = '0; res.done_res = 1'b1; res.status = ST_TIMEOUT;
                                    end else begin
                                        res.cmd_index = 6'd55; res.resp_kind = RK_R1;
                                        phase_next = PH_CMD55;
                                    end
                                end
                                PH_CMD2: begin
                                    res.cmd_index = 6'd3; res.resp_kind = RK_R6;
                                    phase_next = PH_CMD3;
                                end
                                PH_CMD3: begin
                                    rca_next = s_reply_word0[31:16];
                                    res.action = ACT_FAST; res.cmd_arg = HZ_FAST;
                                    phase_next = PH_FAST;
                                end
                                PH_FAST: begin
                                    res.cmd_index = 6'd9; res.cmd_arg = rca_arg;
                                    res.resp_kind = RK_R2; phase_next = PH_CMD9;
                                end
                                PH_CMD9: begin
                                    cap_next = csd_cap;
                                    res.cmd_index = 6'd7; res.cmd_arg = rca_arg;
                                    res.resp_kind = RK_R1B; phase_next = PH_CMD7;
                                end
                                PH_CMD7: begin
                                    if (hc_reg) begin
                                        res = '0; res.done_res = 1'b1;
                                    end else begin
                                        res.cmd_index = 6'd16;
                                        res.cmd_arg = 32'd1 << BLOCK_SHIFT;
                                        res.resp_kind = RK_R1; phase_next = PH_CMD16;
                                    end
                                end
                                PH_ER_START: begin
                                    res.cmd_index = 6'd33; res.cmd_arg = end_reg;
                                    res.resp_kind = RK_R1; phase_next = PH_ER_END;
                                end
                                PH_ER_END: begin
                                    res.cmd_index = 6'd38; res.resp_kind = RK_R1B;
                                    phase_next = PH_ER_ERASE;
                                end
                                PH_ER_ERASE: begin
                                    elapsed_next = '0;
                                    res.cmd_index = 6'd13; res.cmd_arg = rca_arg;
                                    res.resp_kind = RK_R1; phase_next = PH_POLL;
                                end
                                PH_POLL: begin
                                    if (s_reply_word0[12:9] == CARD_TRAN) begin
                                        res = '0; res.done_res = 1'b1;
                                    end else if (timed_out) begin
                                        res = '0; res.done_res = 1'b1; res.status = ST_TIMEOUT;
                                    end else begin
                                        res.cmd_index = 6'd13; res.cmd_arg = rca_arg;
                                        res.resp_kind = RK_R1; phase_next = PH_POLL;
                                    end
                                end
                                default: begin
                                    // Set-block-length and power-off acknowledgments.
                                    res = '0; res.done_res = 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end else if (s_cmd <= CMD_ERASE && phase_reg == PH_IDLE) begin
            unique case (s_cmd)
                CMD_INIT: begin
                    res.action = ACT_SLOW; res.cmd_arg = HZ_SLOW; phase_next = PH_SLOW;
                end
                CMD_DEINIT: begin
                    res.action = ACT_OFF; phase_next = PH_DEINIT;
                end
                CMD_READ, CMD_WRITE: begin
                    if (range_bad) begin
                        res.done_res = 1'b1; res.status = ST_INVAL;
                    end else begin
                        multi_next = s_block_total > 32'd1; ferr_next = ST_OK;
                        res.action = ACT_CMD; res.cmd_arg = addr_first;
                        res.resp_kind = RK_R1; res.xfer_blocks = s_block_total;
                        if (s_cmd == CMD_READ) begin
                            res.cmd_index = (s_block_total > 32'd1) ? 6'd18 : 6'd17;
                            res.data_dir = DIR_READ; phase_next = PH_RD_DATA;
                        end else begin
                            res.cmd_index = (s_block_total > 32'd1) ? 6'd25 : 6'd24;
                            res.data_dir = DIR_WRITE; phase_next = PH_WR_DATA;
                        end
                    end
                end
                default: begin
                    if (range_bad) begin
                        res.done_res = 1'b1; res.status = ST_INVAL;
                    end else begin
                        end_next = addr_last;
                        res.action = ACT_CMD; res.cmd_index = 6'd32;
                        res.cmd_arg = addr_first; res.resp_kind = RK_R1;
                        phase_next = PH_ER_START;
                    end
                end
            endcase
        end
    end

    // Card state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; hc_reg <= 1'b0; v2_reg <= 1'b0; multi_reg <= 1'b0;
            rca_reg <= '0; cap_reg <= '0; elapsed_reg <= '0; end_reg <= '0;
            ferr_reg <= ST_OK; timeout_reg <= 32'd1000;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg <= phase_next; hc_reg <= hc_next; v2_reg <= v2_next;
                multi_reg <= multi_next; rca_reg <= rca_next; cap_reg <= cap_next;
                elapsed_reg <= elapsed_next; end_reg <= end_next; ferr_reg <= ferr_next;
            end
        end
    end

    // Output register with skid stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0; skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_action      = out_reg.action;
    assign m_cmd_index   = out_reg.cmd_index;
    assign m_cmd_arg     = out_reg.cmd_arg;
    assign m_resp_kind   = out_reg.resp_kind;
    assign m_data_dir    = out_reg.data_dir;
    assign m_xfer_blocks = out_reg.xfer_blocks;
    assign m_done_res    = out_reg.done_res;
    assign m_status      = out_reg.status;

    // A result waiting in the skid stage implies the output register is full.
    a_skid_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg) else $error("skid without output");
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(out_reg)) else $error("result lost");
    // The phase is always one-hot.
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg)) else $error("phase not one-hot");
    // Status is only nonzero when a request finishes.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == ST_OK) else $error("stray status");
endmodule

@@ src/sdcs_csd_decode.sv @@
// Capacity decoder for version 1 and version 2 CSD registers.
// Depends on nothing outside itself.
module sdcs_csd_decode (
    input  logic [31:0] word1,
    input  logic [31:0] word2,
    input  logic [31:0] word3,
    output logic [31:0] capacity
);
    logic [22:0] v2_size;
    logic [32:0] v2_cap;
    logic [12:0] v1_size;
    logic [4:0]  v1_exp;
    logic [44:0] v1_wide;

    // Version 2: (C_SIZE + 1) * 1024 with saturation; version 1: shifted size.
    always_comb begin
        v2_size = {1'b0, word2[5:0], word1[31:16]} + 23'd1;
        v2_cap  = {v2_size, 10'd0};
        v1_size = {1'b0, word2[9:0], word1[31:30]} + 13'd1;
        v1_exp  = {2'b0, word1[17:15]} + {1'b0, word2[19:16]};
        if (v1_exp >= 5'd7) begin
            v1_wide = {32'd0, v1_size} << (v1_exp - 5'd7);
        end else begin
            v1_wide = {32'd0, v1_size} >> (5'd7 - v1_exp);
        end
        if (word3[31:30] == 2'd1) begin
            capacity = v2_cap[32] ? 32'hFFFF_FFFF : v2_cap[31:0];
        end else begin
            capacity = v1_wide[31:0];
        end
    end
endmodule
